[design/rle_pkg.sv]
`timescale 1ns / 1ps
// Package for the run-length packet decompressor.
// Holds shared widths, the decoder phase encoding and the result record type.
// No dependencies.
package rle_pkg;

	localparam int SIZE_W  = 14;
	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 8;
	localparam int METH_W  = 2;

	localparam logic [SIZE_W-1:0] CAP_RESET = 14'h3fff;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [METH_W-1:0] METH_COPY = 2'd0;
	localparam logic [METH_W-1:0] METH_RLE  = 2'd1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef enum logic [5:0] {
		PH_DONE   = 6'b000001,
		PH_HDR    = 6'b000010,
		PH_COPY   = 6'b000100,
		PH_CTRL   = 6'b001000,
		PH_RUNVAL = 6'b010000,
		PH_LIT    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic [CNT_W-1:0]  repeat_count;
		logic              status;
		logic              last;
	} rle_res_t;

endpackage

[design/rle_front.sv]
`timescale 1ns / 1ps
// Front end: accepts compressed bytes, tracks header and run state, and
// classifies each byte into zero or one result record. Uses rle_pkg.
module rle_front import rle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              in_fire,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              packet_start,
	output logic              res_push,
	output rle_res_t          res
);

	phase_t            phase_q;
	logic [BYTE_W-1:0] size_low_q;
	logic [SIZE_W-1:0] remain_q;
	logic [CNT_W-1:0]  run_q;
	logic [SIZE_W-1:0] cap_q;

	phase_t            phase_d;
	logic [BYTE_W-1:0] size_low_d;
	logic [SIZE_W-1:0] remain_d;
	logic [CNT_W-1:0]  run_d;

	logic [SIZE_W-1:0] hdr_size;
	logic [METH_W-1:0] hdr_meth;
	logic [SIZE_W-1:0] hdr_len;
	logic [CNT_W-1:0]  ctrl_len;
	logic [SIZE_W-1:0] rem_dec;
	logic [SIZE_W-1:0] rem_run;

	assign hdr_size = {data_byte[SIZE_W-BYTE_W-1:0], size_low_q};
	assign hdr_meth = data_byte[BYTE_W-1 -: METH_W];
	assign hdr_len  = (hdr_size > cap_q) ? cap_q : hdr_size;
	assign ctrl_len = data_byte[7] ? ({1'b0, data_byte[6:0]} + 8'd3)
	                               : ({1'b0, data_byte[6:0]} + 8'd1);
	assign rem_dec  = remain_q - {{(SIZE_W-1){1'b0}}, 1'b1};
	assign rem_run  = remain_q - {{(SIZE_W-CNT_W){1'b0}}, run_q};

	always_comb begin
		phase_d    = phase_q;
		size_low_d = size_low_q;
		remain_d   = remain_q;
		run_d      = run_q;
		res_push   = 1'b0;
		res        = '0;
		if (in_fire) begin
			if (packet_start) begin
				size_low_d = data_byte;
				phase_d    = PH_HDR;
			end else begin
				unique case (phase_q)
					PH_HDR: begin
						if (hdr_meth != METH_COPY && hdr_meth != METH_RLE) begin
							phase_d    = PH_DONE;
							res_push   = 1'b1;
							res.status = STATUS_ERR;
							res.last   = 1'b1;
						end else begin
							remain_d = hdr_len;
							run_d    = '0;
							if (hdr_len == '0) begin
								phase_d  = PH_DONE;
								res_push = 1'b1;
								res.last = 1'b1;
							end else begin
								phase_d = (hdr_meth == METH_RLE) ? PH_CTRL : PH_COPY;
							end
						end
					end
					PH_COPY: begin
						remain_d         = rem_dec;
						res_push         = 1'b1;
						res.out_byte     = data_byte;
						res.repeat_count = 8'd1;
						res.last         = (rem_dec == '0);
						if (rem_dec == '0) phase_d = PH_DONE;
					end
					PH_CTRL: begin
						run_d   = ({{(SIZE_W-CNT_W){1'b0}}, ctrl_len} > remain_q)
						          ? remain_q[CNT_W-1:0] : ctrl_len;
						phase_d = data_byte[7] ? PH_RUNVAL : PH_LIT;
					end
					PH_RUNVAL: begin
						remain_d         = rem_run;
						run_d            = '0;
						res_push         = 1'b1;
						res.out_byte     = data_byte;
						res.repeat_count = run_q;
						res.last         = (rem_run == '0);
						phase_d          = (rem_run == '0) ? PH_DONE : PH_CTRL;
					end
					PH_LIT: begin
						run_d            = run_q - 8'd1;
						remain_d         = rem_dec;
						res_push         = 1'b1;
						res.out_byte     = data_byte;
						res.repeat_count = 8'd1;
						res.last         = (rem_dec == '0);
						if (rem_dec == '0)
							phase_d = PH_DONE;
						else if (run_q == 8'd1)
							phase_d = PH_CTRL;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_DONE;
			size_low_q <= '0;
			remain_q   <= '0;
			run_q      <= '0;
			cap_q      <= CAP_RESET;
		end else begin
			phase_q    <= phase_d;
			size_low_q <= size_low_d;
			remain_q   <= remain_d;
			run_q      <= run_d;
			if (cfg_we) cap_q <= cfg_data;
		end
	end

endmodule

[design/rle_fifo.sv]
`timescale 1ns / 1ps
// Short result queue between decoder front end and output stage.
// Depth from rle_pkg::QDEPTH. Uses rle_pkg.
module rle_fifo import rle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  rle_res_t wdata,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output rle_res_t rdata
);

	rle_res_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QDEPTH-1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

[design/rle_back.sv]
`timescale 1ns / 1ps
// Output stage: pulls result records from the queue into the output
// register and presents them as valid/ready transactions. Uses rle_pkg.
module rle_back import rle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  rle_res_t          q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic [CNT_W-1:0]  repeat_count,
	output logic              status,
	output logic              last
);

	logic     valid_q;
	rle_res_t res_q;

	assign q_pop        = q_not_empty && (!valid_q || out_ready);
	assign out_valid    = valid_q;
	assign out_byte     = res_q.out_byte;
	assign repeat_count = res_q.repeat_count;
	assign status       = res_q.status;
	assign last         = res_q.last;

	always_ff @(posedge clk) begin
		if (q_pop) res_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[design/rle_packet_decompressor_top.sv]
`timescale 1ns / 1ps
// Run-length packet decompressor, top level. Takes one compressed byte per
// clock and emits at most one (byte, repeat count) result per byte. A result
// is written into the result queue as its byte is taken and then moves on
// into the output register; the sustained rate is one byte per cycle, set by
// the decoder state update in the front end. in_ready drops only when the
// two-entry result queue is full because the output side is stalled. The
// capacity register is always ready, takes effect at the next packet header,
// and resets to 16383. Depends on rle_pkg, rle_front, rle_fifo and rle_back.
module rle_packet_decompressor_top import rle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              packet_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic [CNT_W-1:0]  repeat_count,
	output logic              status,
	output logic              last
);

	logic     q_full;
	logic     q_not_empty;
	logic     q_pop;
	logic     res_push;
	rle_res_t res;
	rle_res_t q_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;

	rle_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.in_fire      (in_valid && in_ready),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.res_push     (res_push),
		.res          (res)
	);

	rle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.wdata     (res),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (q_data)
	);

	rle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.repeat_count (repeat_count),
		.status       (status),
		.last         (last)
	);

endmodule
